/* src/cdsd_pkg.sv */
// package for the calendar date shifter
// types, constants and month length helpers shared by the step unit and top level
package cdsd_pkg;

    localparam logic [13:0] YEAR_LIMIT = 14'd16383;
    localparam logic [8:0]  REM_LAST   = 9'd399;
    localparam logic [8:0]  REM_ONE    = 9'd1;
    localparam logic [13:0] RECIP_400  = 14'd10486;
    localparam int          RECIP_SHIFT = 22;
    localparam logic [8:0]  CYCLE_400  = 9'd400;
    localparam logic [3:0]  MONTH_JAN  = 4'd1;
    localparam logic [3:0]  MONTH_FEB  = 4'd2;
    localparam logic [3:0]  MONTH_DEC  = 4'd12;
    localparam logic [4:0]  DAY_FIRST  = 5'd1;
    localparam logic [4:0]  DAY_DEC_END = 5'd31;

    typedef struct packed {
        logic [4:0]         day_in;
        logic [3:0]         month_in;
        logic [13:0]        year_in;
        logic               before_era_in;
        logic signed [15:0] day_count;
    } request_t;

    typedef struct packed {
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [13:0] year_out;
        logic        before_era_out;
        logic        date_invalid;
    } result_t;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic        bc;
    } date_t;

    typedef struct packed {
        date_t      date;
        logic [8:0] rem;
        logic       stop;
    } step_t;

    // leap rule on the year modulo 400
    function automatic logic is_leap(input logic [8:0] rem);
        is_leap = (rem[1:0] == 2'd0) && (rem != 9'd100) && (rem != 9'd200)
                  && (rem != 9'd300);
    endfunction

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                        len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
        endcase
        month_days = len;
    endfunction

endpackage

/* src/cdsd_step.sv */
// one-day step unit: moves a date forward or back by one day
// depends on cdsd_pkg
module cdsd_step (
    input  cdsd_pkg::date_t date,
    input  logic [8:0]      rem,
    input  logic            back,
    output cdsd_pkg::step_t nxt
);
    import cdsd_pkg::*;

    logic       leap;
    logic [4:0] len_cur;
    logic [4:0] len_prev;
    logic [8:0] rem_up;
    logic [8:0] rem_down;

    assign leap     = is_leap(rem);
    assign len_cur  = month_days(date.month, leap);
    assign len_prev = month_days(date.month - 4'd1, leap);
    assign rem_up   = (rem == REM_LAST) ? 9'd0 : rem + 9'd1;
    assign rem_down = (rem == 9'd0) ? REM_LAST : rem - 9'd1;

    always_comb
    begin
        nxt.date = date;
        nxt.rem  = rem;
        nxt.stop = 1'b0;
        if (!back)
        begin
            if (date.day < len_cur)
            begin
                nxt.date.day = date.day + 5'd1;
            end
            else if (date.month < MONTH_DEC)
            begin
                nxt.date.month = date.month + 4'd1;
                nxt.date.day   = DAY_FIRST;
            end
            else if (!date.bc && date.year >= YEAR_LIMIT)
            begin
                nxt.stop = 1'b1;
            end
            else
            begin
                nxt.date.month = MONTH_JAN;
                nxt.date.day   = DAY_FIRST;
                if (date.bc)
                begin
                    if (date.year == 14'd1)
                    begin
                        nxt.date.bc = 1'b0;
                        nxt.rem     = REM_ONE;
                    end
                    else
                    begin
                        nxt.date.year = date.year - 14'd1;
                        nxt.rem       = rem_down;
                    end
                end
                else
                begin
                    nxt.date.year = date.year + 14'd1;
                    nxt.rem       = rem_up;
                end
            end
        end
        else
        begin
            if (date.day > DAY_FIRST)
            begin
                nxt.date.day = date.day - 5'd1;
            end
            else if (date.month > MONTH_JAN)
            begin
                nxt.date.month = date.month - 4'd1;
                nxt.date.day   = len_prev;
            end
            else if (date.bc && date.year >= YEAR_LIMIT)
            begin
                nxt.stop = 1'b1;
            end
            else
            begin
                nxt.date.month = MONTH_DEC;
                nxt.date.day   = DAY_DEC_END;
                if (!date.bc)
                begin
                    if (date.year == 14'd1)
                    begin
                        nxt.date.bc = 1'b1;
                        nxt.rem     = REM_ONE;
                    end
                    else
                    begin
                        nxt.date.year = date.year - 14'd1;
                        nxt.rem       = rem_down;
                    end
                end
                else
                begin
                    nxt.date.year = date.year + 14'd1;
                    nxt.rem       = rem_up;
                end
            end
        end
    end

endmodule

/* src/calendar_date_shift_days_top.sv */
// top level of the calendar date shifter: check sequencer around the step unit
// depends on cdsd_pkg and cdsd_step
//
//   channel   handshake            payload
//   request   start / busy         request (request_t)
//   result    done, one cycle      result  (result_t)
//
// an item passes from start to done through S_DIV for the year modulo 400,
// S_CHECK for the date check, S_STEP at one day per cycle through the step unit,
// and a register for the result. an invalid date finishes straight after S_CHECK.
// reaching the year limit ends the walk early.
// busy is high from the accepting edge until done. rst_n clears the sequencer.
// the receiver cannot stall; done is a single-cycle strobe.
module calendar_date_shift_days_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  cdsd_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output cdsd_pkg::result_t  result
);
    import cdsd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_CHECK = 4'b0100,
        S_STEP  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    date_t      date_reg;
    logic [8:0] rem_reg;
    logic [5:0] quot_reg;
    logic [15:0] count_reg;
    logic       back_reg;
    logic       done_reg;
    result_t    result_reg;

    logic [27:0] prod;
    logic [13:0] quot_x400;
    logic [8:0]  rem_calc;
    logic        date_ok;
    step_t       step;

    assign prod      = {14'd0, date_reg.year} * {14'd0, RECIP_400};
    assign quot_x400 = {8'd0, quot_reg} * {5'd0, CYCLE_400};
    assign rem_calc  = 9'(date_reg.year - quot_x400);
    assign date_ok   = (date_reg.day >= DAY_FIRST) && (date_reg.month >= MONTH_JAN)
                       && (date_reg.month <= MONTH_DEC) && (date_reg.year != 14'd0)
                       && (date_reg.day <= month_days(date_reg.month, is_leap(rem_calc)));

    cdsd_step u_step (
        .date (date_reg),
        .rem  (rem_reg),
        .back (back_reg),
        .nxt  (step)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (start) state_next = S_DIV;
            S_DIV:   state_next = S_CHECK;
            S_CHECK: state_next = date_ok ? S_STEP : S_IDLE;
            S_STEP:  if (count_reg == 16'd0) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == S_CHECK) && !date_ok)
                         || ((state_reg == S_STEP) && (count_reg == 16'd0));
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    date_reg.day   <= request.day_in;
                    date_reg.month <= request.month_in;
                    date_reg.year  <= request.year_in;
                    date_reg.bc    <= request.before_era_in;
                    back_reg       <= request.day_count[15];
                    count_reg      <= request.day_count[15]
                                      ? 16'(-request.day_count) : request.day_count;
                end
            end
            S_DIV:
            begin
                quot_reg <= prod[RECIP_SHIFT +: 6];
            end
            S_CHECK:
            begin
                rem_reg <= rem_calc;
                if (!date_ok)
                begin
                    result_reg.day_out        <= date_reg.day;
                    result_reg.month_out      <= date_reg.month;
                    result_reg.year_out       <= date_reg.year;
                    result_reg.before_era_out <= date_reg.bc;
                    result_reg.date_invalid   <= 1'b1;
                end
            end
            S_STEP:
            begin
                if (count_reg == 16'd0)
                begin
                    result_reg.day_out        <= date_reg.day;
                    result_reg.month_out      <= date_reg.month;
                    result_reg.year_out       <= date_reg.year;
                    result_reg.before_era_out <= date_reg.bc;
                    result_reg.date_invalid   <= 1'b0;
                end
                else if (step.stop)
                begin
                    count_reg <= 16'd0;
                end
                else
                begin
                    date_reg  <= step.date;
                    rem_reg   <= step.rem;
                    count_reg <= count_reg - 16'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// testbench for calendar_date_shift_days_top: directed and random dates shifted by signed day
// counts, each result checked against an in-bench date stepper; depends on cdsd_pkg and the rtl
module testbench;

    import cdsd_pkg::*;

    localparam int unsigned YEAR_MAX  = 16383;
    localparam int unsigned FEBRUARY  = 2;
    localparam int unsigned DECEMBER  = 12;
    localparam int          IDLE_PCT  = 7;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    request_t pending_items[$];
    result_t  expected_dates[$];
    int       item_total = 0;
    int       issued = 0;
    int       checked = 0;
    int       mismatches = 0;
    logic     taken = 1'b0;

    calendar_date_shift_days_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit leap_year(int unsigned y);
        return (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
    endfunction

    function automatic int unsigned month_length(int unsigned m, int unsigned y);
        int unsigned len;
        case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            FEBRUARY:              len = leap_year(y) ? 29 : 28;
            default:               len = 0;
        endcase
        return len;
    endfunction

    function automatic result_t shift_date(request_t r);
        result_t     res;
        int unsigned d, m, y, steps;
        int          cnt;
        bit          bc, backward;
        d = r.day_in;
        m = r.month_in;
        y = r.year_in;
        bc = r.before_era_in;
        cnt = r.day_count;
        backward = cnt < 0;
        steps = backward ? -cnt : cnt;
        if (d < 1 || m < 1 || m > DECEMBER || y == 0 || d > month_length(m, y))
        begin
            res.day_out = r.day_in;
            res.month_out = r.month_in;
            res.year_out = r.year_in;
            res.before_era_out = r.before_era_in;
            res.date_invalid = 1'b1;
            return res;
        end
        for (int i = 0; i < steps; i++)
        begin
            if (!backward)
            begin
                if (d < month_length(m, y))
                    d++;
                else if (m < DECEMBER)
                begin
                    m++;
                    d = 1;
                end
                else
                begin
                    if (!bc && y >= YEAR_MAX)
                        break;
                    m = 1;
                    d = 1;
                    if (bc)
                    begin
                        y--;
                        // no year zero between 1 bc and 1 ad
                        if (y == 0)
                        begin
                            y = 1;
                            bc = 1'b0;
                        end
                    end
                    else
                        y++;
                end
            end
            else
            begin
                if (d > 1)
                    d--;
                else if (m > 1)
                begin
                    m--;
                    d = month_length(m, y);
                end
                else
                begin
                    if (bc && y >= YEAR_MAX)
                        break;
                    m = DECEMBER;
                    d = 31;
                    if (bc)
                        y++;
                    else
                    begin
                        y--;
                        if (y == 0)
                        begin
                            y = 1;
                            bc = 1'b1;
                        end
                    end
                end
            end
        end
        res.day_out = 5'(d);
        res.month_out = 4'(m);
        res.year_out = 14'(y);
        res.before_era_out = bc;
        res.date_invalid = 1'b0;
        return res;
    endfunction

    function automatic request_t make_item(int unsigned d, int unsigned m, int unsigned y,
                                           bit bc, int cnt);
        request_t r;
        r.day_in = 5'(d);
        r.month_in = 4'(m);
        r.year_in = 14'(y);
        r.before_era_in = bc;
        r.day_count = 16'(cnt);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at item %0d: %s", checked, msg);
        mismatches++;
    endtask

    task automatic check_date(input result_t got);
        result_t want;
        if (expected_dates.size() == 0)
        begin
            report_mismatch("result with no item pending");
            return;
        end
        want = expected_dates.pop_front();
        if (got.day_out !== want.day_out)
            report_mismatch($sformatf("day_out %0d, expected %0d", got.day_out, want.day_out));
        if (got.month_out !== want.month_out)
            report_mismatch($sformatf("month_out %0d, expected %0d",
                                      got.month_out, want.month_out));
        if (got.year_out !== want.year_out)
            report_mismatch($sformatf("year_out %0d, expected %0d", got.year_out, want.year_out));
        if (got.before_era_out !== want.before_era_out)
            report_mismatch($sformatf("before_era_out %0b, expected %0b",
                                      got.before_era_out, want.before_era_out));
        if (got.date_invalid !== want.date_invalid)
            report_mismatch($sformatf("date_invalid %0b, expected %0b",
                                      got.date_invalid, want.date_invalid));
        checked++;
    endtask

    // driver: new item at the falling edge once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n && (!start || taken))
        begin
            if (pending_items.size() != 0 &&
                ((issued >= 40 && issued < 75) || $urandom_range(99) >= IDLE_PCT))
            begin
                request <= pending_items.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: results first, then the item accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                check_date(result);
            if (start && !busy)
            begin
                expected_dates.push_back(shift_date(request));
                issued++;
            end
            taken <= start && !busy;
        end
    end

    initial
    begin
        int unsigned     d, m, y, pick;
        bit              bc;
        logic [15:0]     cnt16;

        pending_items.push_back(make_item(1, 1, 1, 0, 0));
        pending_items.push_back(make_item(31, 12, 1, 1, 1));
        pending_items.push_back(make_item(1, 1, 1, 0, -1));
        pending_items.push_back(make_item(29, 2, 2000, 0, 1));
        pending_items.push_back(make_item(29, 2, 1900, 0, 5));
        pending_items.push_back(make_item(28, 2, 1900, 0, 1));
        pending_items.push_back(make_item(29, 2, 2023, 0, 3));
        pending_items.push_back(make_item(29, 2, 2024, 0, -366));
        pending_items.push_back(make_item(29, 2, 4, 1, 365));
        pending_items.push_back(make_item(1, 3, 1, 1, -1));
        pending_items.push_back(make_item(0, 6, 2020, 0, 10));
        pending_items.push_back(make_item(31, 4, 2020, 1, 10));
        pending_items.push_back(make_item(15, 0, 2020, 0, 10));
        pending_items.push_back(make_item(15, 13, 2020, 0, 10));
        pending_items.push_back(make_item(31, 15, 9999, 1, -1));
        pending_items.push_back(make_item(10, 5, 0, 1, 7));
        pending_items.push_back(make_item(31, 12, 9999, 0, 32767));
        pending_items.push_back(make_item(1, 1, 9999, 1, -32768));
        pending_items.push_back(make_item(1, 1, 50, 1, 32767));
        pending_items.push_back(make_item(1, 1, 40, 0, -32768));
        pending_items.push_back(make_item(31, 12, 2023, 0, 1));
        pending_items.push_back(make_item(1, 1, 2024, 0, -1));
        pending_items.push_back(make_item(30, 4, 2023, 0, 1));

        for (int k = 0; k < 77; k++)
        begin
            pick = $urandom_range(99);
            bc = $urandom_range(1);
            if (pick < 15)
            begin
                // noise over the full day and month field ranges and years up to 9999, some bad dates
                d = $urandom_range(31);
                m = $urandom_range(15);
                y = $urandom_range(9999);
            end
            else
            begin
                m = $urandom_range(12, 1);
                if (pick < 35)
                    y = $urandom_range(6, 1);
                else if (pick < 45)
                    y = 100 * $urandom_range(99, 1);
                else
                    y = $urandom_range(9999, 1);
                d = $urandom_range(month_length(m, y), 1);
                if ($urandom_range(3) == 0)
                    d = $urandom_range(1) ? 1 : month_length(m, y);
            end
            // long shifts only now and then, they cost a cycle per day
            if (k % 20 == 19)
                cnt16 = 16'($urandom_range(65535));
            else
                cnt16 = 16'(int'($urandom_range(2000)) - 1000);
            pending_items.push_back(make_item(d, m, y, bc, $signed(cnt16)));
        end
        item_total = pending_items.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (issued < item_total || expected_dates.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
